/* sv/fqs_pkg.sv */
package fqs_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W = 3;
  localparam int QUEUE_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic [POS_W-1:0]         found_position;
  } result_t;

  // per-cell control for one transfer
  typedef struct packed {
    logic capture;
    logic load;
    logic shift;
    logic search;
    logic live;
  } cell_ctrl_t;

endpackage

/* sv/fqs_cell.sv */
module fqs_cell (
  input  logic                               clk,
  input  fqs_pkg::cell_ctrl_t                ctrl,
  input  logic signed [fqs_pkg::WORD_W-1:0]  push_word,
  input  logic signed [fqs_pkg::WORD_W-1:0]  key,
  input  logic signed [fqs_pkg::WORD_W-1:0]  neighbor_word,
  output logic signed [fqs_pkg::WORD_W-1:0]  word,
  output logic                               hit
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= push_word;
    end else if (ctrl.shift) begin
      word <= neighbor_word;
    end
    // compare against the word held before this transfer
    if (ctrl.capture) begin
      hit <= ctrl.search && ctrl.live && (word == key);
    end
  end

endmodule

/* sv/fqs_result.sv */
module fqs_result #(
  parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    stage_valid,
  input  logic [1:0]                              stage_mode,
  input  logic [1:0]                              stage_status,
  input  logic signed [fqs_pkg::WORD_W-1:0]       stage_popped,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]        stage_occ,
  input  logic [QUEUE_DEPTH-1:0]                  hits,
  output logic                                    take,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output fqs_pkg::result_t                        result
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CALC_W = (OCC_W > fqs_pkg::POS_W) ? OCC_W : fqs_pkg::POS_W;

  logic [IDX_W-1:0]  top_idx;
  logic              any_hit;
  logic [CALC_W-1:0] pos_calc;
  fqs_pkg::result_t  result_next;

  // newest match is the highest live cell index with a hit
  always_comb begin
    top_idx = '0;
    any_hit = 1'b0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (hits[k]) begin
        top_idx = IDX_W'(k);
        any_hit = 1'b1;
      end
    end
  end

  assign pos_calc = CALC_W'(stage_occ) - CALC_W'(1) - CALC_W'(top_idx);

  always_comb begin
    result_next.status = stage_status;
    result_next.popped_value = stage_popped;
    result_next.found_position = '0;
    if (stage_mode == fqs_pkg::MODE_SEARCH && stage_status == fqs_pkg::ST_OK) begin
      if (any_hit) begin
        result_next.found_position = pos_calc[fqs_pkg::POS_W-1:0];
      end else begin
        result_next.status = fqs_pkg::ST_NOT_FOUND;
      end
    end
  end

  assign take = stage_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (take) begin
      result <= result_next;
    end
  end

endmodule

/* sv/fifo_queue_with_search_top.sv */
// an item transfer loads the stage registers and the cell hits; result_valid rises
//   when the result stage takes them into the output register
// one item per cycle unless result_ready stalls the output; each cell compares
//   its word at transfer; the result stage then registers the newest match
// reset: clears the fill count and the pipeline valid flags; stored words are not
//   cleared, a word is only read once it has been pushed
module fifo_queue_with_search_top #(
  parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  fqs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output fqs_pkg::result_t result
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  // fill count, cell k holds a live word when k < occ
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;

  // chain of cells, index 0 is the oldest word
  logic signed [fqs_pkg::WORD_W-1:0] words [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]            hits;
  fqs_pkg::cell_ctrl_t               ctrl [QUEUE_DEPTH];

  // first stage: per-transfer info waiting for the result stage
  logic                              stage_valid;
  logic [1:0]                        stage_mode;
  logic [1:0]                        stage_status;
  logic signed [fqs_pkg::WORD_W-1:0] stage_popped;
  logic [OCC_W-1:0]                  stage_occ;
  logic                              take;

  logic       xfer;
  logic       is_full;
  logic       is_empty;
  logic       push_ok;
  logic       pop_ok;
  logic [1:0] status_next;

  assign xfer       = item_valid && item_ready;
  assign item_ready = !stage_valid || take;
  assign is_full    = (occ == OCC_W'(QUEUE_DEPTH));
  assign is_empty   = (occ == '0);
  assign push_ok    = xfer && item.mode == fqs_pkg::MODE_PUSH && !is_full;
  assign pop_ok     = xfer && item.mode == fqs_pkg::MODE_POP && !is_empty;

  // early status; a search with no hit becomes not found in the result stage
  always_comb begin
    case (item.mode)
      fqs_pkg::MODE_PUSH:   status_next = is_full ? fqs_pkg::ST_OVERFLOW : fqs_pkg::ST_OK;
      fqs_pkg::MODE_POP:    status_next = is_empty ? fqs_pkg::ST_EMPTY : fqs_pkg::ST_OK;
      fqs_pkg::MODE_SEARCH: status_next = is_empty ? fqs_pkg::ST_EMPTY : fqs_pkg::ST_OK;
      default:              status_next = fqs_pkg::ST_OK;
    endcase
  end

  always_comb begin
    occ_next = occ;
    if (push_ok) begin
      occ_next = occ + OCC_W'(1);
    end else if (pop_ok) begin
      occ_next = occ - OCC_W'(1);
    end
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic signed [fqs_pkg::WORD_W-1:0] neighbor;

    // last cell keeps its own word on a shift; it drops out of the live range
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign neighbor = words[k];
    end else begin : g_mid
      assign neighbor = words[k+1];
    end

    always_comb begin
      ctrl[k].capture = xfer;
      ctrl[k].load    = push_ok && (occ == OCC_W'(k));
      ctrl[k].shift   = pop_ok;
      ctrl[k].search  = (item.mode == fqs_pkg::MODE_SEARCH);
      ctrl[k].live    = (OCC_W'(k) < occ);
    end

    fqs_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl[k]),
      .push_word     (item.value),
      .key           (item.value),
      .neighbor_word (neighbor),
      .word          (words[k]),
      .hit           (hits[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      stage_valid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (xfer) begin
        stage_valid <= 1'b1;
      end else if (take) begin
        stage_valid <= 1'b0;
      end
    end
    if (xfer) begin
      stage_mode   <= item.mode;
      stage_status <= status_next;
      stage_popped <= pop_ok ? words[0] : '0;
      stage_occ    <= occ;
    end
  end

  fqs_result #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_result (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage_mode   (stage_mode),
    .stage_status (stage_status),
    .stage_popped (stage_popped),
    .stage_occ    (stage_occ),
    .hits         (hits),
    .take         (take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> occ == $past(occ) + OCC_W'(1))
    else $error("push did not grow fill count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> occ == $past(occ) - OCC_W'(1))
    else $error("pop did not shrink fill count");

  a_miss_no_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != fqs_pkg::ST_OK |-> result.found_position == '0)
    else $error("position reported without a match");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    take |=> result_valid)
    else $error("stage handoff lost a result");
`endif

endmodule
